// ===== rtl/core/urlenc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// urlenc_pkg
// shared types and character constants for the url percent encoder
// ----------------------------------------------------------------------------
package urlenc_pkg;

    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 2;
    localparam int SLASH_W = 2;

    // output tdata width, padded to whole bytes
    localparam int RESULT_W = COUNT_W + 3 * CHAR_W;
    localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] COUNT_PLAIN   = 2'd1;
    localparam logic [COUNT_W-1:0] COUNT_ESCAPED = 2'd3;

    localparam logic [SLASH_W-1:0] SLASH_MAX = 2'd3;

    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DQUOTE    = 8'h22;
    localparam logic [CHAR_W-1:0] CH_PERCENT   = 8'h25;
    localparam logic [CHAR_W-1:0] CH_SLASH     = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_LESS      = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_GREATER   = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_QUESTION  = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_LBRACKET  = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_RBRACKET  = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_CARET     = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_BACKTICK  = 8'h60;
    localparam logic [CHAR_W-1:0] CH_LBRACE    = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE    = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_DEL       = 8'h7F;
    localparam logic [CHAR_W-1:0] CH_DIGIT0    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_ALPHA_OFS = 8'h37;  // 'A' - 10

    typedef struct packed {
        logic [CHAR_W-1:0]  out_third;
        logic [CHAR_W-1:0]  out_second;
        logic [CHAR_W-1:0]  out_first;
        logic [COUNT_W-1:0] out_count;
    } result_t;

    typedef struct packed {
        logic [SLASH_W-1:0] slash_count;
        logic               bracket_escape;
    } scan_state_t;

endpackage : urlenc_pkg
`default_nettype wire

// ===== rtl/core/urlenc_classify.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// urlenc_classify
// per-byte escape decision, hex digit generation and scan state update
// ----------------------------------------------------------------------------
module urlenc_classify (
    input  wire logic [urlenc_pkg::CHAR_W-1:0] char_in,
    input  wire logic                          last_in,
    input  wire urlenc_pkg::scan_state_t       state_cur,
    output      urlenc_pkg::scan_state_t       state_next,
    output      urlenc_pkg::result_t           result
);
    import urlenc_pkg::*;

    function automatic logic [CHAR_W-1:0] hex_digit(input logic [3:0] nib);
        logic [CHAR_W-1:0] wide;
        wide = {4'h0, nib};
        if (nib < 4'd10)
        begin
            return wide + CH_DIGIT0;
        end
        return wide + CH_ALPHA_OFS;
    endfunction

    logic [SLASH_W-1:0] slash_upd;
    logic               bracket_upd;
    logic               always_esc;
    logic               bracket_char;
    logic               escape;

    always_comb
    begin
        // slash count and bracket flag update before the byte is classified
        slash_upd = state_cur.slash_count;
        if (char_in == CH_SLASH && state_cur.slash_count != SLASH_MAX)
        begin
            slash_upd = state_cur.slash_count + 2'd1;
        end
        bracket_upd = state_cur.bracket_escape || (slash_upd == SLASH_MAX)
                      || (char_in == CH_QUESTION);

        always_esc = (char_in <= CH_SPACE) || (char_in >= CH_DEL)
                     || (char_in == CH_DQUOTE) || (char_in == CH_LESS)
                     || (char_in == CH_GREATER) || (char_in == CH_BACKSLASH)
                     || (char_in == CH_CARET) || (char_in == CH_BACKTICK)
                     || ((char_in >= CH_LBRACE) && (char_in <= CH_RBRACE));
        bracket_char = (char_in == CH_LBRACKET) || (char_in == CH_RBRACKET);
        escape = always_esc || (bracket_upd && bracket_char);

        if (escape)
        begin
            result.out_count  = COUNT_ESCAPED;
            result.out_first  = CH_PERCENT;
            result.out_second = hex_digit(char_in[7:4]);
            result.out_third  = hex_digit(char_in[3:0]);
        end
        else
        begin
            result.out_count  = COUNT_PLAIN;
            result.out_first  = char_in;
            result.out_second = '0;
            result.out_third  = '0;
        end

        // end of url starts a fresh scan
        if (last_in)
        begin
            state_next.slash_count    = '0;
            state_next.bracket_escape = 1'b0;
        end
        else
        begin
            state_next.slash_count    = slash_upd;
            state_next.bracket_escape = bracket_upd;
        end
    end

endmodule : urlenc_classify
`default_nettype wire

// ===== rtl/core/url_percent_encoder_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// url_percent_encoder_top
// percent-encodes a url stream, one byte in and one result out per transfer
// ----------------------------------------------------------------------------
// output: the result of an input transfer is registered and shows on the output in the next cycle
// throughput: one byte per cycle while m_axis_tready is high; a stalled result register holds off new bytes
// reset: rst_n clears the result valid flag, the slash count and the
//   bracket flag; the block accepts bytes in the first cycle after reset
// ----------------------------------------------------------------------------
module url_percent_encoder_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // input stream
    input  wire logic                           s_axis_tvalid,
    output      logic                           s_axis_tready,
    input  wire logic [7:0]                     s_axis_tdata,   // [7:0] char_in
    input  wire logic                           s_axis_tlast,   // last_in
    // output stream
    output      logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [1:0] out_count, [9:2] out_first, [17:10] out_second,
    // [25:18] out_third, [31:26] zero
    output      logic [urlenc_pkg::TDATA_W-1:0] m_axis_tdata,
    output      logic                           m_axis_tlast    // last_out
);
    import urlenc_pkg::*;

    scan_state_t state_reg;
    scan_state_t state_next;
    result_t     result_next;
    result_t     result_reg;
    logic        last_reg;
    logic        valid_reg;
    logic        in_xfer;

    // the result register frees up in the same cycle it is drained, so a
    // new byte is taken whenever the output is empty or being taken
    assign s_axis_tready = !valid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    urlenc_classify u_classify (
        .char_in    (s_axis_tdata[CHAR_W-1:0]),
        .last_in    (s_axis_tlast),
        .state_cur  (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // scan state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                state_reg <= state_next;
            end
            if (s_axis_tready)
            begin
                valid_reg <= s_axis_tvalid;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            result_reg <= result_next;
            last_reg   <= s_axis_tlast;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{(TDATA_W - RESULT_W){1'b0}}, result_reg};
    assign m_axis_tlast  = last_reg;

endmodule : url_percent_encoder_top
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// streams url bytes through url_percent_encoder_top and checks every result
// against an in-bench encoder: a directed table of extremes, escape classes
// and bracket cases, then random urls and noise with random idling on both
// sides of the block
// ----------------------------------------------------------------------------
module testbench;

    import urlenc_pkg::*;

    localparam int RANDOM_ITEMS = 1125;
    localparam int STALL_LIMIT  = 1000;   // cycles without any transfer
    localparam int IDLE_PCT     = 13;
    localparam int MAX_PRINTS   = 60;

    // one row of the directed table; typed rows carry a hand-written result
    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic               last;
        logic               typed;
        logic [COUNT_W-1:0] count;
        logic [CHAR_W-1:0]  first;
        logic [CHAR_W-1:0]  second;
        logic [CHAR_W-1:0]  third;
    } stim_row_t;

    // expected output transfer
    typedef struct packed {
        logic    last;
        result_t res;
    } encoded_t;

    localparam int DIRECTED_ROWS = 25;

    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // byte range extremes, including the zero byte outside the nominal range
        '{8'h01,        1'b0, 1'b1, COUNT_ESCAPED, CH_PERCENT, "0", "1"},
        '{8'h00,        1'b0, 1'b1, COUNT_ESCAPED, CH_PERCENT, "0", "0"},
        '{8'hFF,        1'b0, 1'b1, COUNT_ESCAPED, CH_PERCENT, "F", "F"},
        '{8'h80,        1'b0, 1'b1, COUNT_ESCAPED, CH_PERCENT, "8", "0"},
        // edges of the printable range
        '{CH_SPACE,     1'b0, 1'b1, COUNT_ESCAPED, CH_PERCENT, "2", "0"},
        '{8'h21,        1'b0, 1'b1, COUNT_PLAIN,   8'h21,      8'h00, 8'h00},
        '{8'h7E,        1'b0, 1'b1, COUNT_PLAIN,   8'h7E,      8'h00, 8'h00},
        '{CH_DEL,       1'b0, 1'b1, COUNT_ESCAPED, CH_PERCENT, "7", "F"},
        // always-escaped punctuation
        '{CH_DQUOTE,    1'b0, 1'b1, COUNT_ESCAPED, CH_PERCENT, "2", "2"},
        '{CH_LESS,      1'b0, 1'b1, COUNT_ESCAPED, CH_PERCENT, "3", "C"},
        '{CH_GREATER,   1'b0, 1'b1, COUNT_ESCAPED, CH_PERCENT, "3", "E"},
        '{CH_BACKSLASH, 1'b0, 1'b1, COUNT_ESCAPED, CH_PERCENT, "5", "C"},
        '{CH_CARET,     1'b0, 1'b1, COUNT_ESCAPED, CH_PERCENT, "5", "E"},
        '{CH_BACKTICK,  1'b0, 1'b1, COUNT_ESCAPED, CH_PERCENT, "6", "0"},
        '{CH_LBRACE,    1'b0, 1'b1, COUNT_ESCAPED, CH_PERCENT, "7", "B"},
        '{8'h7C,        1'b0, 1'b1, COUNT_ESCAPED, CH_PERCENT, "7", "C"},
        '{CH_RBRACE,    1'b0, 1'b1, COUNT_ESCAPED, CH_PERCENT, "7", "D"},
        // brackets stay plain until the third slash, then the url ends
        '{CH_LBRACKET,  1'b0, 1'b0, '0, '0, '0, '0},
        '{CH_SLASH,     1'b0, 1'b0, '0, '0, '0, '0},
        '{CH_SLASH,     1'b0, 1'b0, '0, '0, '0, '0},
        '{CH_RBRACKET,  1'b0, 1'b0, '0, '0, '0, '0},
        '{CH_SLASH,     1'b0, 1'b0, '0, '0, '0, '0},
        '{CH_LBRACKET,  1'b1, 1'b0, '0, '0, '0, '0},
        // fresh url: a question mark alone turns bracket escaping on
        '{CH_QUESTION,  1'b0, 1'b0, '0, '0, '0, '0},
        '{CH_RBRACKET,  1'b1, 1'b0, '0, '0, '0, '0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = 8'h00;
    logic                s_axis_tlast = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic                m_axis_tlast;

    // in-bench copy of the scanner state
    logic [SLASH_W-1:0]  slashes_seen = '0;
    logic                brackets_escaped = 1'b0;

    encoded_t            expected_q[$];
    int                  error_count = 0;
    int                  stall_cycles = 0;
    logic                steady_run = 1'b0;   // no idling on either side

    url_percent_encoder_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // upper-case ascii hex digit of the low nibble
    function automatic logic [CHAR_W-1:0] hex_ascii(input logic [3:0] nibble);
        if (nibble < 4'd10)
            return CH_DIGIT0 + CHAR_W'(nibble);
        return CH_ALPHA_OFS + CHAR_W'(nibble);
    endfunction

    // encodes one byte and advances the slash count and bracket flag
    function automatic encoded_t encode_char(input logic [CHAR_W-1:0] ch,
                                             input logic last);
        encoded_t enc;
        logic     escape;
        if (ch == CH_SLASH && slashes_seen != SLASH_MAX)
            slashes_seen = slashes_seen + SLASH_W'(1);
        // flag is updated before the byte itself is classified
        if (slashes_seen == SLASH_MAX || ch == CH_QUESTION)
            brackets_escaped = 1'b1;
        escape = (ch <= CH_SPACE) || (ch >= CH_DEL) ||
                 (ch == CH_DQUOTE) || (ch == CH_LESS) || (ch == CH_GREATER) ||
                 (ch == CH_BACKSLASH) || (ch == CH_CARET) || (ch == CH_BACKTICK) ||
                 (ch >= CH_LBRACE && ch <= CH_RBRACE) ||
                 (brackets_escaped && (ch == CH_LBRACKET || ch == CH_RBRACKET));
        if (escape)
        begin
            enc.res.out_count  = COUNT_ESCAPED;
            enc.res.out_first  = CH_PERCENT;
            enc.res.out_second = hex_ascii(ch[7:4]);
            enc.res.out_third  = hex_ascii(ch[3:0]);
        end
        else
        begin
            enc.res.out_count  = COUNT_PLAIN;
            enc.res.out_first  = ch;
            enc.res.out_second = '0;
            enc.res.out_third  = '0;
        end
        enc.last = last;
        // end of url clears the scanner
        if (last)
        begin
            slashes_seen     = '0;
            brackets_escaped = 1'b0;
        end
        return enc;
    endfunction

    // weighted byte picker that favors the characters that move the scanner
    function automatic logic [CHAR_W-1:0] pick_url_char();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 35)
            return 8'h21 + CHAR_W'($urandom_range(93));   // printable ascii
        if (roll < 55)
            return CH_SLASH;
        if (roll < 65)
            return $urandom_range(1) ? CH_LBRACKET : CH_RBRACKET;
        if (roll < 70)
            return CH_QUESTION;
        return CHAR_W'($urandom_range(255, 1));
    endfunction

    task automatic report_error(input string msg);
        if (error_count < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // drives one byte, idling at random first; returns at the accepting edge
    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
        while (!steady_run && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // output side: random backpressure outside the steady stretch
    always @(posedge clk)
    begin
        m_axis_tready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
    end

    // compare each output transfer with the oldest expectation
    always @(posedge clk)
    begin
        encoded_t want;
        result_t  got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[RESULT_W-1:0];
            if (expected_q.size() == 0)
                report_error($sformatf("unexpected result tdata %h", m_axis_tdata));
            else
            begin
                want = expected_q.pop_front();
                if (got.out_count !== want.res.out_count)
                    report_error($sformatf("out_count %h, want %h",
                                           got.out_count, want.res.out_count));
                if (got.out_first !== want.res.out_first)
                    report_error($sformatf("out_first %h, want %h",
                                           got.out_first, want.res.out_first));
                if (got.out_second !== want.res.out_second)
                    report_error($sformatf("out_second %h, want %h",
                                           got.out_second, want.res.out_second));
                if (got.out_third !== want.res.out_third)
                    report_error($sformatf("out_third %h, want %h",
                                           got.out_third, want.res.out_third));
                if (m_axis_tlast !== want.last)
                    report_error($sformatf("last_out %b, want %b",
                                           m_axis_tlast, want.last));
            end
            // padding above the result fields must read as zero
            if (m_axis_tdata[TDATA_W-1:RESULT_W] !== '0)
                report_error($sformatf("tdata padding %h not zero",
                                       m_axis_tdata[TDATA_W-1:RESULT_W]));
        end
    end

    // watchdog: too long without a transfer on either side ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        encoded_t enc;
        int       sent;
        int       url_len;
        logic     noise;
        logic [CHAR_W-1:0] ch;
        logic     last;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (DIRECTED[i])
        begin
            send_char(DIRECTED[i].ch, DIRECTED[i].last);
            enc = encode_char(DIRECTED[i].ch, DIRECTED[i].last);
            if (DIRECTED[i].typed)
            begin
                enc.res.out_count  = DIRECTED[i].count;
                enc.res.out_first  = DIRECTED[i].first;
                enc.res.out_second = DIRECTED[i].second;
                enc.res.out_third  = DIRECTED[i].third;
                enc.last           = DIRECTED[i].last;
            end
            expected_q.push_back(enc);
        end

        // random urls, mostly well formed with a terminating last byte,
        // the rest short bursts of arbitrary bytes with random last flags
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            noise   = ($urandom_range(99) < 15);
            url_len = noise ? $urandom_range(6, 1) : $urandom_range(40, 1);
            for (int k = 0; k < url_len; k++)
            begin
                steady_run = (sent >= 300 && sent < 550);
                if (noise)
                begin
                    ch   = CHAR_W'($urandom_range(255, 1));
                    last = 1'($urandom_range(1));
                end
                else
                begin
                    ch   = pick_url_char();
                    last = (k == url_len - 1);
                end
                send_char(ch, last);
                expected_q.push_back(encode_char(ch, last));
                sent++;
            end
        end
        steady_run = 1'b0;
        s_axis_tvalid <= 1'b0;

        // drain, then leave room for any stray result
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
